// ===== sv/tqa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqa_pkg
// Shared constants and elaboration-time helpers for the triangle angle and
// quality pipeline: accumulator formats and the CORDIC degree table.
// ----------------------------------------------------------------------------
package tqa_pkg;

  localparam int ACC_FRAC = 40;
  localparam int ZW       = 48;
  localparam int XW       = 36;
  localparam int SCALE_W  = 30;
  localparam logic [31:0] THR_RESET = 32'd4295;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] part;
    logic [63:0] k;
    term = udiv64(64'd1 << 62, n);
    sum  = '0;
    k    = '0;
    for (int it = 0; it < 64; it++) begin
      if (term != 64'd0) begin
        part = udiv64(term, 2 * k + 64'd1);
        if (k[0]) sum = sum - part;
        else sum = sum + part;
        term = udiv64(term, n * n);
        k = k + 64'd1;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan_pow2(input int i);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] part;
    logic [63:0] k;
    term = 64'd1 << (62 - i);
    sum  = '0;
    k    = '0;
    for (int it = 0; it < 64; it++) begin
      if (term != 64'd0) begin
        part = udiv64(term, 2 * k + 64'd1);
        if (k[0]) sum = sum - part;
        else sum = sum + part;
        term = term >> (2 * i);
        k = k + 64'd1;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] deg_entry(input int i);
    logic [63:0] quarter;
    logic [63:0] a;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] cap;
    logic        sat;
    quarter = 4 * atan_inv(64'd5) - atan_inv(64'd239);
    a       = (i == 0) ? quarter : atan_pow2(i);
    cap     = 64'd1 << ACC_FRAC;
    q       = udiv64(a, quarter);
    r       = a - q * quarter;
    sat     = (q > cap);
    for (int k = 0; k < ACC_FRAC; k++) begin
      if (!sat) begin
        q = q << 1;
        r = r << 1;
        if (r >= quarter) begin
          r = r - quarter;
          q = q + 64'd1;
        end
        if (q > cap) sat = 1'b1;
      end
    end
    if (sat) q = cap;
    return q * 64'd45;
  endfunction

endpackage

// ===== sv/tqa_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqa_isqrt
// Pipelined integer square root, one result bit per register stage.
// One operand per cycle.
// ----------------------------------------------------------------------------
module tqa_isqrt #(
  parameter int IW = 64
) (
  input  logic            clk,
  input  logic [IW-1:0]   n,
  output logic [IW/2-1:0] r
);

  localparam int RW = IW / 2;

  logic [RW:0]   rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [IW-1:0] src_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW:0]   rp;
    logic [RW-1:0] op;
    logic [IW-1:0] sp;
    logic [RW+2:0] cand;
    logic [RW+2:0] trial;

    if (k == 0) begin : g_first
      assign rp = '0;
      assign op = '0;
      assign sp = n;
    end else begin : g_next
      assign rp = rem_q[k-1];
      assign op = root_q[k-1];
      assign sp = src_q[k-1];
    end

    assign cand  = {rp, sp[IW-1:IW-2]};
    assign trial = {1'b0, op, 2'b01};

    always_ff @(posedge clk) begin
      if (cand >= trial) begin
        rem_q[k]  <= (RW+1)'(cand - trial);
        root_q[k] <= {op[RW-2:0], 1'b1};
      end else begin
        rem_q[k]  <= cand[RW:0];
        root_q[k] <= {op[RW-2:0], 1'b0};
      end
      src_q[k] <= {sp[IW-3:0], 2'b00};
    end
  end

  assign r = root_q[RW-1];

endmodule

// ===== sv/tqa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqa_div
// Pipelined restoring divider with saturation: q = min(n / d, 2^QW - 1).
// One quotient bit per stage, one operand per cycle.
// ----------------------------------------------------------------------------
module tqa_div #(
  parameter int NW = 96,
  parameter int DW = 64,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] lo_q  [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic          ovf_q [QW+1];

  logic [HW-1:0] hi;
  assign hi = n[NW-1:QW];

  always_ff @(posedge clk) begin
    ovf_q[0] <= (CW'(hi) >= CW'(d));
    rem_q[0] <= DW'(hi);
    lo_q[0]  <= n[QW-1:0];
    quo_q[0] <= '0;
    den_q[0] <= d;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] cand;
    assign cand = {rem_q[k-1], lo_q[k-1][QW-1]};

    always_ff @(posedge clk) begin
      if (cand >= {1'b0, den_q[k-1]}) begin
        rem_q[k] <= DW'(cand - {1'b0, den_q[k-1]});
        quo_q[k] <= {quo_q[k-1][QW-2:0], 1'b1};
      end else begin
        rem_q[k] <= cand[DW-1:0];
        quo_q[k] <= {quo_q[k-1][QW-2:0], 1'b0};
      end
      lo_q[k]  <= {lo_q[k-1][QW-2:0], 1'b0};
      den_q[k] <= den_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
    end
  end

  assign q = ovf_q[QW] ? '1 : quo_q[QW];

endmodule

// ===== sv/triangle_angle_quality_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_angle_quality_top
// Interior angles (degrees) and sine-based shape quality of one mesh face.
//
//   channel  | handshake            | beat
//   ---------+----------------------+-----------------------------------------
//   input    | start, busy          | face_tag, ax..cz
//   config   | cfg_valid, cfg_ready | cfg_data (degenerate_threshold)
//   result   | done                 | face_tag_out, angle_a..c, quality,
//            |                      | degenerate
//
// One face per cycle; busy stays low. Each result passes through the chain of
// pipelined square roots, the half-cosine and quality dividers and the CORDIC
// stages. Reset clears the valid bits and loads the threshold; there is no
// clearing pass. The receiver cannot stall, so the pipeline advances every
// cycle.
// ----------------------------------------------------------------------------
module triangle_angle_quality_top #(
  parameter int COORD_BITS   = 32,
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] face_tag,
  input  logic [31:0] ax,
  input  logic [31:0] ay,
  input  logic [31:0] az,
  input  logic [31:0] bx,
  input  logic [31:0] by_coord,
  input  logic [31:0] bz,
  input  logic [31:0] cx,
  input  logic [31:0] cy,
  input  logic [31:0] cz,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] face_tag_out,
  output logic [23:0] angle_a,
  output logic [23:0] angle_b,
  output logic [23:0] angle_c,
  output logic [31:0] quality,
  output logic        degenerate
);

  localparam int EW  = COORD_BITS + 1;
  localparam int SW  = $clog2(COORD_BITS + 1);
  localparam int SCW = tqa_pkg::SCALE_W;
  localparam int ZW  = tqa_pkg::ZW;
  localparam int XW  = tqa_pkg::XW;
  localparam int RSH = tqa_pkg::ACC_FRAC - FRAC_BITS;
  localparam int QNW = 34 + FRAC_BITS - 1;

  localparam int ST_N   = 6;
  localparam int ST_LEN = ST_N + 31;
  localparam int ST_CH  = ST_LEN + 2 + 33;
  localparam int ST_DG  = ST_CH + 1;
  localparam int ST_SQ  = ST_DG + 32;
  localparam int ST_Q   = ST_SQ + 3 + 33;
  localparam int ST_A   = ST_SQ + CORDIC_STEPS + 1;
  localparam int ST_PRE = (ST_A > ST_Q) ? ST_A : ST_Q;
  localparam int ZF_N   = ST_CH - ST_N;
  localparam int DOT_N  = ST_LEN + 1 - ST_N;
  localparam int DG_N   = ST_PRE - ST_DG;
  localparam int QD     = ST_PRE - ST_Q;
  localparam int AD     = ST_PRE - ST_A;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic in_fire;
  assign in_fire = start && !busy;

  logic [31:0] thr;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= tqa_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // valid and tag line
  logic        vld_d [ST_PRE];
  logic [31:0] tag_d [ST_PRE];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ST_PRE; k++) vld_d[k] <= 1'b0;
    end else begin
      vld_d[0] <= in_fire;
      for (int k = 1; k < ST_PRE; k++) vld_d[k] <= vld_d[k-1];
    end
  end
  always_ff @(posedge clk) begin
    tag_d[0] <= face_tag;
    for (int k = 1; k < ST_PRE; k++) tag_d[k] <= tag_d[k-1];
  end

  // stage 1: edge vectors
  logic signed [COORD_BITS-1:0] pa [3];
  logic signed [COORD_BITS-1:0] pb [3];
  logic signed [COORD_BITS-1:0] pc [3];
  always_comb begin
    pa[0] = COORD_BITS'({32'd0, ax});
    pa[1] = COORD_BITS'({32'd0, ay});
    pa[2] = COORD_BITS'({32'd0, az});
    pb[0] = COORD_BITS'({32'd0, bx});
    pb[1] = COORD_BITS'({32'd0, by_coord});
    pb[2] = COORD_BITS'({32'd0, bz});
    pc[0] = COORD_BITS'({32'd0, cx});
    pc[1] = COORD_BITS'({32'd0, cy});
    pc[2] = COORD_BITS'({32'd0, cz});
  end

  logic signed [EW-1:0] edg [3][3];
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      edg[0][j] <= EW'(pb[j]) - EW'(pa[j]);
      edg[1][j] <= EW'(pc[j]) - EW'(pa[j]);
      edg[2][j] <= EW'(pc[j]) - EW'(pb[j]);
    end
  end

  // stage 2: magnitudes and their union
  logic [COORD_BITS-1:0] mag  [3][3];
  logic                  neg  [3][3];
  logic [COORD_BITS-1:0] orv;
  logic [COORD_BITS-1:0] orv_next;
  always_comb begin
    orv_next = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        orv_next = orv_next | COORD_BITS'(edg[i][j][EW-1] ? -edg[i][j] : edg[i][j]);
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        mag[i][j] <= COORD_BITS'(edg[i][j][EW-1] ? -edg[i][j] : edg[i][j]);
        neg[i][j] <= edg[i][j][EW-1];
      end
    orv <= orv_next;
  end

  // stage 3: common scale shift
  logic [SW-1:0]         blen;
  logic [SW-1:0]         shamt;
  logic [COORD_BITS-1:0] mag3 [3][3];
  logic                  neg3 [3][3];
  always_comb begin
    blen = '0;
    for (int b = 0; b < COORD_BITS; b++)
      if (orv[b]) blen = SW'(b + 1);
  end
  always_ff @(posedge clk) begin
    shamt <= (blen > SW'(SCW)) ? blen - SW'(SCW) : '0;
    mag3  <= mag;
    neg3  <= neg;
  end

  // stage 4: scaled signed components
  logic signed [SCW:0] sc [3][3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        if (neg3[i][j]) sc[i][j] <= -$signed({1'b0, SCW'(mag3[i][j] >> shamt)});
        else sc[i][j] <= $signed({1'b0, SCW'(mag3[i][j] >> shamt)});
      end
  end

  // stage 5: squares and dot terms
  logic [2*SCW-1:0]      sq [3][3];
  logic signed [2*SCW+1:0] pr [3][3];
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) sq[i][j] <= (2*SCW)'(sc[i][j] * sc[i][j]);
      pr[0][j] <= sc[0][j] * sc[1][j];
      pr[1][j] <= sc[2][j] * sc[0][j];
      pr[2][j] <= sc[1][j] * sc[2][j];
    end
  end

  // stage 6: squared lengths and dot products
  logic [2*SCW+1:0]   nsq [3];
  logic signed [63:0] dot [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      nsq[i] <= (2*SCW+2)'(sq[i][0]) + (2*SCW+2)'(sq[i][1]) + (2*SCW+2)'(sq[i][2]);
    dot[0] <= 64'(pr[0][0]) + 64'(pr[0][1]) + 64'(pr[0][2]);
    dot[1] <= -(64'(pr[1][0]) + 64'(pr[1][1]) + 64'(pr[1][2]));
    dot[2] <= 64'(pr[2][0]) + 64'(pr[2][1]) + 64'(pr[2][2]);
  end

  logic zf_d [ZF_N];
  always_ff @(posedge clk) begin
    zf_d[0] <= (nsq[0] == '0) || (nsq[1] == '0) || (nsq[2] == '0);
    for (int k = 1; k < ZF_N; k++) zf_d[k] <= zf_d[k-1];
  end

  logic signed [63:0] dot_d [3][DOT_N];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dot_d[i][0] <= dot[i];
      for (int k = 1; k < DOT_N; k++) dot_d[i][k] <= dot_d[i][k-1];
    end
  end

  // edge lengths
  logic [SCW:0] len [3];
  for (genvar i = 0; i < 3; i++) begin : g_len
    tqa_isqrt #(.IW(2*SCW+2)) u_len (.clk(clk), .n(nsq[i]), .r(len[i]));
  end

  // length products, then clamped numerators
  logic [2*SCW+1:0] pl [3];
  always_ff @(posedge clk) begin
    pl[0] <= len[0] * len[1];
    pl[1] <= len[2] * len[0];
    pl[2] <= len[1] * len[2];
  end

  logic [63:0] numc [3];
  logic [63:0] den  [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [63:0] s;
      s = $signed(64'(pl[i])) + dot_d[i][DOT_N-1];
      den[i] <= {1'b0, pl[i], 1'b0};
      if (s < 0) numc[i] <= '0;
      else if (64'(s) > {1'b0, pl[i], 1'b0}) numc[i] <= {1'b0, pl[i], 1'b0};
      else numc[i] <= 64'(s);
    end
  end

  // half-angle cosine terms
  logic [31:0] ch [3];
  for (genvar i = 0; i < 3; i++) begin : g_ch
    tqa_div #(.NW(96), .DW(64), .QW(32)) u_ch (
      .clk(clk), .n({numc[i], 32'd0}), .d(den[i]), .q(ch[i])
    );
  end

  logic        dg_d [DG_N+1];
  logic [31:0] chq  [3];
  logic [63:0] sp   [3];
  always_ff @(posedge clk) begin
    dg_d[0] <= zf_d[ZF_N-1] || (ch[0] <= thr) || (ch[1] <= thr) || (ch[2] <= thr);
    for (int k = 1; k <= DG_N; k++) dg_d[k] <= dg_d[k-1];
    for (int i = 0; i < 3; i++) begin
      chq[i] <= ch[i];
      sp[i]  <= 64'(ch[i] * (33'h1_0000_0000 - {1'b0, ch[i]}));
    end
  end

  logic [31:0] rest [3];
  logic [31:0] sroot [3];
  logic [31:0] xr [3];
  logic [31:0] yr [3];
  for (genvar i = 0; i < 3; i++) begin : g_sq
    assign rest[i] = (chq[i] == '0) ? '1 : 32'd0 - chq[i];
    tqa_isqrt #(.IW(64)) u_s (.clk(clk), .n(sp[i]), .r(sroot[i]));
    tqa_isqrt #(.IW(64)) u_x (.clk(clk), .n({chq[i], 32'd0}), .r(xr[i]));
    tqa_isqrt #(.IW(64)) u_y (.clk(clk), .n({rest[i], 32'd0}), .r(yr[i]));
  end

  // CORDIC vectoring, one micro-rotation per stage
  logic signed [XW-1:0] cor_x [3][CORDIC_STEPS];
  logic signed [XW-1:0] cor_y [3][CORDIC_STEPS];
  logic signed [ZW-1:0] cor_z [3][CORDIC_STEPS];
  for (genvar a = 0; a < 3; a++) begin : g_cor
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic [ZW-1:0] TV = ZW'(tqa_pkg::deg_entry(i));
      logic signed [XW-1:0] xp;
      logic signed [XW-1:0] yp;
      logic signed [ZW-1:0] zp;
      if (i == 0) begin : g_first
        assign xp = $signed(XW'(xr[a]));
        assign yp = $signed(XW'(yr[a]));
        assign zp = '0;
      end else begin : g_next
        assign xp = cor_x[a][i-1];
        assign yp = cor_y[a][i-1];
        assign zp = cor_z[a][i-1];
      end
      always_ff @(posedge clk) begin
        if (yp >= 0) begin
          cor_x[a][i] <= xp + (yp >>> i);
          cor_y[a][i] <= yp - (xp >>> i);
          cor_z[a][i] <= zp + $signed(TV);
        end else begin
          cor_x[a][i] <= xp - (yp >>> i);
          cor_y[a][i] <= yp + (xp >>> i);
          cor_z[a][i] <= zp - $signed(TV);
        end
      end
    end
  end

  logic [23:0] ang [3];
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      logic [ZW+1:0] th;
      logic [ZW+1:0] rnd;
      th  = (cor_z[a][CORDIC_STEPS-1] < 0) ? '0 : {1'b0, cor_z[a][CORDIC_STEPS-1], 1'b0};
      rnd = (th + ((ZW+2)'(1) << (RSH - 1))) >> RSH;
      ang[a] <= (rnd > (ZW+2)'(24'hFF_FFFF)) ? 24'hFF_FFFF : rnd[23:0];
    end
  end

  // sines and quality
  logic [31:0] sn [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sn[i] <= sroot[i][31] ? '1 : {sroot[i][30:0], 1'b0};
  end

  logic [31:0] pab;
  logic [31:0] sc_d;
  logic [33:0] ssum;
  logic [31:0] prod;
  logic [33:0] ssum2;
  always_ff @(posedge clk) begin
    pab   <= 32'((64'(sn[0]) * 64'(sn[1])) >> 32);
    sc_d  <= sn[2];
    ssum  <= 34'(sn[0]) + 34'(sn[1]) + 34'(sn[2]);
    prod  <= 32'((64'(pab) * 64'(sc_d)) >> 32);
    ssum2 <= ssum;
  end

  logic [31:0] qv;
  tqa_div #(.NW(QNW), .DW(32), .QW(32)) u_q (
    .clk(clk), .n({ssum2, (FRAC_BITS-1)'(0)}), .d(prod), .q(qv)
  );

  // align both branches
  logic [31:0] q_al;
  logic [23:0] a_al [3];
  if (QD == 0) begin : g_qd0
    assign q_al = qv;
  end else begin : g_qd
    logic [31:0] qd [QD];
    always_ff @(posedge clk) begin
      qd[0] <= qv;
      for (int k = 1; k < QD; k++) qd[k] <= qd[k-1];
    end
    assign q_al = qd[QD-1];
  end
  if (AD == 0) begin : g_ad0
    assign a_al = ang;
  end else begin : g_ad
    logic [23:0] ad [AD][3];
    always_ff @(posedge clk) begin
      ad[0] <= ang;
      for (int k = 1; k < AD; k++) ad[k] <= ad[k-1];
    end
    assign a_al = ad[AD-1];
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_d[ST_PRE-1];
    end
  end
  always_ff @(posedge clk) begin
    face_tag_out <= tag_d[ST_PRE-1];
    degenerate   <= dg_d[DG_N];
    angle_a      <= dg_d[DG_N] ? '0 : a_al[0];
    angle_b      <= dg_d[DG_N] ? '0 : a_al[1];
    angle_c      <= dg_d[DG_N] ? '0 : a_al[2];
    quality      <= dg_d[DG_N] ? '0 : q_al;
  end

endmodule
